/* src/auto_load_key_typist_assert.svh */
// Assertion macros shared by the auto-load key typist sources.
`ifndef AUTO_LOAD_KEY_TYPIST_ASSERT_SVH
`define AUTO_LOAD_KEY_TYPIST_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent, outside reset.
`define ALKT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("alkt: next-cycle check failed");

// The consequent must hold in the cycle after reset is applied.
`define ALKT_ASSERT_AFTER_RESET(label, clk, rst_n, cons) \
    label: assert property (@(posedge clk) !rst_n |=> (cons)) \
        else $error("alkt: reset check failed");

`endif

/* src/alkt_pkg.sv */
`default_nettype none
package alkt_pkg;

    // Item kinds carried in the input tuser.
    localparam logic [1:0] MODE_READ     = 2'd0;
    localparam logic [1:0] MODE_FRAME    = 2'd1;
    localparam logic [1:0] MODE_ACTIVATE = 2'd2;

    // Machine families.
    localparam logic [1:0] FAM_48K   = 2'd0;
    localparam logic [1:0] FAM_128K  = 2'd1;
    localparam logic [1:0] FAM_SE    = 2'd2;

    // Register indexes on the configuration port.
    localparam logic REG_MACHINE_FAMILY = 1'b0;
    localparam logic REG_LOAD_CODE      = 1'b1;

    localparam int          NSTEPS   = 20;
    localparam logic [7:0]  KEY_NONE = 8'h00;
    localparam logic [7:0]  BYTE_IDLE = 8'hFF;

    typedef enum logic [4:0] {
        S_IDLE, S_WAIT_ROWS, S_J, S_Q1, S_Q2, S_ENT, S_ENT_ONLY, S_L, S_O, S_A,
        S_D, S_EXT, S_KW_CODE, S_C, S_CO, S_CD, S_CE, S_DOWN, S_SEL, S_PAUSE
    } t_step;

    typedef enum logic [2:0] {
        SEQ_JPP, SEQ_JPPI, SEQ_ENTER, SEQ_DOWN_CODE, SEQ_LOADPP, SEQ_LOADCODE
    } t_seq;

    typedef struct packed {
        logic [1:0] machine_family;
        logic       load_code;
    } t_cfg;

    typedef struct packed {
        logic [7:0] key0;
        logic [7:0] key1;
        t_step      next;
        logic [4:0] wait_frames;
    } t_step_row;

    // Key code: bit 7 marks a key, bits 5:3 the half-row, bits 2:0 the column.
    function automatic logic [7:0] key_code(input logic [2:0] row, input logic [2:0] col);
        return {2'b10, row, col};
    endfunction

    // Per-step keys, fixed successor and frame delay.
    function automatic t_step_row step_info(input t_step s);
        t_step_row r;
        r = '{KEY_NONE, KEY_NONE, S_IDLE, 5'd0};
        case (s)
            S_J:        r = '{key_code(3'd6, 3'd3), KEY_NONE, S_Q1, 5'd8};
            S_Q1:       r = '{key_code(3'd7, 3'd1), key_code(3'd5, 3'd0), S_Q2, 5'd0};
            S_Q2:       r = '{key_code(3'd7, 3'd1), key_code(3'd5, 3'd0), S_IDLE, 5'd5};
            S_ENT:      r = '{key_code(3'd6, 3'd0), KEY_NONE, S_IDLE, 5'd0};
            S_ENT_ONLY: r = '{key_code(3'd6, 3'd0), KEY_NONE, S_IDLE, 5'd3};
            S_L:        r = '{key_code(3'd6, 3'd1), KEY_NONE, S_O, 5'd2};
            S_O:        r = '{key_code(3'd5, 3'd1), KEY_NONE, S_A, 5'd0};
            S_A:        r = '{key_code(3'd1, 3'd0), KEY_NONE, S_D, 5'd4};
            S_D:        r = '{key_code(3'd1, 3'd2), KEY_NONE, S_Q1, 5'd4};
            S_EXT:      r = '{key_code(3'd0, 3'd0), key_code(3'd7, 3'd1), S_KW_CODE, 5'd0};
            S_KW_CODE:  r = '{key_code(3'd5, 3'd2), KEY_NONE, S_ENT, 5'd4};
            S_C:        r = '{key_code(3'd0, 3'd3), KEY_NONE, S_CO, 5'd0};
            S_CO:       r = '{key_code(3'd5, 3'd1), KEY_NONE, S_CD, 5'd4};
            S_CD:       r = '{key_code(3'd1, 3'd2), KEY_NONE, S_CE, 5'd0};
            S_CE:       r = '{key_code(3'd2, 3'd2), KEY_NONE, S_ENT, 5'd4};
            S_DOWN:     r = '{key_code(3'd0, 3'd0), key_code(3'd4, 3'd4), S_SEL, 5'd4};
            S_SEL:      r = '{key_code(3'd6, 3'd0), KEY_NONE, S_PAUSE, 5'd10};
            S_PAUSE:    r = '{KEY_NONE, KEY_NONE, S_L, 5'd28};
            default:    r = '{KEY_NONE, KEY_NONE, S_IDLE, 5'd0};
        endcase
        return r;
    endfunction

    // Byte seen on a read for one key: column bit low if its half-row is selected.
    function automatic logic [7:0] press(input logic [7:0] port, input logic [7:0] key);
        logic [7:0] r;
        r = BYTE_IDLE;
        if (key[7] && !port[key[5:3]]) begin
            r = ~(8'd1 << key[2:0]);
        end
        return r;
    endfunction

    // True when exactly one half-row is selected.
    function automatic logic single_row(input logic [7:0] port);
        logic r;
        case (port)
            8'hFE, 8'hFD, 8'hFB, 8'hF7, 8'hEF, 8'hDF, 8'hBF, 8'h7F: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    // A step that types keys, waits for rows or pauses: any valid step but idle.
    function automatic logic step_live(input t_step s);
        return (s != S_IDLE) && (s < 5'(NSTEPS));
    endfunction

endpackage
`default_nettype wire

/* src/alkt_cfg.sv */
`default_nettype none
module alkt_cfg
    import alkt_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    t_cfg r_cfg;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    // Register writes in the access cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_wr) begin
            case (paddr[2])
                REG_MACHINE_FAMILY: r_cfg.machine_family <= pwdata[1:0];
                default:            r_cfg.load_code      <= pwdata[0];
            endcase
        end
    end

    // Read-back of the selected register.
    always_comb begin
        prdata = '0;
        case (paddr[2])
            REG_MACHINE_FAMILY: prdata = {30'd0, r_cfg.machine_family};
            default:            prdata = {31'd0, r_cfg.load_code};
        endcase
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

/* src/alkt_core.sv */
`default_nettype none
module alkt_core
    import alkt_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [1:0] i_mode,
    input  wire logic [7:0] i_port_high,
    input  wire t_cfg       i_cfg,
    output logic [7:0]      o_key_data,
    output logic            o_typing_active
);

    t_step      r_cur, n_cur;
    t_step      r_pend, n_pend;
    logic [4:0] r_delay, n_delay;
    logic [7:0] r_rows, n_rows;
    t_seq       r_seq, n_seq;

    t_step_row  w_info;
    t_step_row  w_pend_info;
    logic [7:0] w_rows_or;
    logic [4:0] w_delay_ld;
    t_step      w_first;
    t_step      w_after_q;
    t_seq       w_act_seq;

    // Table lookups and the decoded successors of the latched sequence.
    always_comb begin
        w_info      = step_info(r_cur);
        w_pend_info = step_info(r_pend);
        w_rows_or   = r_rows | (single_row(i_port_high) ? ~i_port_high : 8'h00);
        case (r_seq)
            SEQ_JPP, SEQ_JPPI:         w_first = S_J;
            SEQ_ENTER:                 w_first = S_ENT_ONLY;
            SEQ_DOWN_CODE:             w_first = S_DOWN;
            SEQ_LOADPP, SEQ_LOADCODE:  w_first = S_L;
            default:                   w_first = S_IDLE;
        endcase
        case (r_seq)
            SEQ_JPP, SEQ_LOADPP:       w_after_q = S_ENT;
            SEQ_JPPI:                  w_after_q = S_EXT;
            SEQ_LOADCODE, SEQ_DOWN_CODE: w_after_q = S_C;
            default:                   w_after_q = S_IDLE;
        endcase
        case (i_cfg.machine_family)
            FAM_48K:  w_act_seq = i_cfg.load_code ? SEQ_JPPI : SEQ_JPP;
            FAM_128K: w_act_seq = i_cfg.load_code ? SEQ_DOWN_CODE : SEQ_ENTER;
            FAM_SE:   w_act_seq = i_cfg.load_code ? SEQ_LOADCODE : SEQ_LOADPP;
            default:  w_act_seq = SEQ_JPP;
        endcase
    end

    // Next state and read byte for the item being transferred.
    always_comb begin
        n_cur      = r_cur;
        n_pend     = r_pend;
        n_delay    = r_delay;
        n_rows     = r_rows;
        n_seq      = r_seq;
        w_delay_ld = r_delay;
        o_key_data = BYTE_IDLE;
        if (i_accept) begin
            unique case (i_mode)
                MODE_READ: begin
                    if (r_delay == 5'd0) begin
                        if (r_cur == S_WAIT_ROWS) begin
                            n_rows = w_rows_or;
                            if (w_rows_or == 8'hFF) begin
                                n_pend = w_first;
                            end
                        end else if (step_live(r_cur)) begin
                            o_key_data = press(i_port_high, w_info.key0)
                                       & press(i_port_high, w_info.key1);
                            n_pend = (r_cur == S_Q2) ? w_after_q : w_info.next;
                        end
                    end
                end
                MODE_FRAME: begin
                    n_rows = 8'h00;
                    if (r_pend != r_cur) begin
                        n_cur      = r_pend;
                        w_delay_ld = w_pend_info.wait_frames;
                    end
                    n_delay = (w_delay_ld != 5'd0) ? w_delay_ld - 5'd1 : 5'd0;
                end
                MODE_ACTIVATE: begin
                    n_seq  = w_act_seq;
                    n_cur  = S_WAIT_ROWS;
                    n_pend = S_WAIT_ROWS;
                end
                default: begin
                end
            endcase
        end
        o_typing_active = step_live(n_cur);
    end

    // Sequencer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur   <= S_IDLE;
            r_pend  <= S_IDLE;
            r_delay <= '0;
            r_rows  <= '0;
            r_seq   <= SEQ_JPP;
        end else begin
            r_cur   <= n_cur;
            r_pend  <= n_pend;
            r_delay <= n_delay;
            r_rows  <= n_rows;
            r_seq   <= n_seq;
        end
    end

endmodule
`default_nettype wire

/* src/alkt_out_reg.sv */
`default_nettype none
module alkt_out_reg (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_load,
    input  wire logic [7:0] i_key_data,
    input  wire logic       i_typing_active,
    input  wire logic       i_out_ready,
    output logic            o_free,
    output logic            o_valid,
    output logic [7:0]      o_key_data,
    output logic            o_typing_active
);

    logic       r_valid;
    logic [7:0] r_key_data;
    logic       r_active;

    // The register can take a new result when empty or being drained.
    assign o_free = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    // Payload, held while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_key_data <= i_key_data;
            r_active   <= i_typing_active;
        end
    end

    assign o_valid         = r_valid;
    assign o_key_data      = r_key_data;
    assign o_typing_active = r_active;

endmodule
`default_nettype wire

/* src/auto_load_key_typist.sv */
// Auto-load key typist: answers keyboard port reads with injected keystrokes.
// Input stream: s_axis_tuser carries the item kind (0 port read, 1 frame end,
// 2 activate); s_axis_tdata carries the upper byte of the port address.
// Output stream: one transfer per input transfer, in order. m_axis_tdata is
// the byte the read returns (0xFF for frame end and activate items) and
// m_axis_tuser[0] is high while a key sequence is in progress.
// Configuration: APB registers machine_family at 0x0 and load_code at 0x4,
// sampled when an activate item is taken; write them only while idle.
// The result of an input transfer appears on the output in the cycle after it.
// Throughput is one item per cycle unless the receiver stalls: all of an item's
// work is done by the sequencer logic between the state and output registers.
// When the receiver stalls, the output register holds its result and the
// input side accepts one more item only as the held result drains.
// Synchronous reset returns the sequencer to inactive, clears the row and
// delay counters, empties the output register and clears both registers.
`default_nettype none
module auto_load_key_typist
    import alkt_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] port_high
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] mode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] key_data
    output logic [0:0]       m_axis_tuser,   // [0] typing_active
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    t_cfg       w_cfg;
    logic       w_accept;
    logic       w_free;
    logic [7:0] w_key_data;
    logic       w_active;

    assign s_axis_tready = w_free;
    assign w_accept      = s_axis_tvalid && w_free;

    alkt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    alkt_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (w_accept),
        .i_mode          (s_axis_tuser),
        .i_port_high     (s_axis_tdata),
        .i_cfg           (w_cfg),
        .o_key_data      (w_key_data),
        .o_typing_active (w_active)
    );

    alkt_out_reg u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (w_accept),
        .i_key_data      (w_key_data),
        .i_typing_active (w_active),
        .i_out_ready     (m_axis_tready),
        .o_free          (w_free),
        .o_valid         (m_axis_tvalid),
        .o_key_data      (m_axis_tdata),
        .o_typing_active (m_axis_tuser[0])
    );

`include "auto_load_key_typist_assert.svh"

    // Every accepted item produces a result in the next cycle.
    `ALKT_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, w_accept, m_axis_tvalid)
    // An accepted activate item always starts a sequence.
    `ALKT_ASSERT_NEXT(a_activate_starts, i_clk, i_rst_n,
        w_accept && (s_axis_tuser == MODE_ACTIVATE), m_axis_tuser[0])
    // Frame end and activate items never inject keys.
    `ALKT_ASSERT_NEXT(a_non_read_idle, i_clk, i_rst_n,
        w_accept && (s_axis_tuser != MODE_READ), m_axis_tdata == BYTE_IDLE)
    // Reset empties the output register.
    `ALKT_ASSERT_AFTER_RESET(a_reset_empty, i_clk, i_rst_n, !m_axis_tvalid)

endmodule
`default_nettype wire

/* dv/auto_load_key_typist_test.sv */
`timescale 1ns / 1ps
module auto_load_key_typist_test;
    import alkt_pkg::*;

    // Item kind that the block passes over without effect.
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int MAX_REPORTS = 10;
    localparam int PHASES = 8;

    typedef struct {
        logic [7:0] key_data;
        logic       typing_active;
    } t_reply;

    // Tracks the typing sequencer and holds the replies still owed by the block.
    class typist_tracker;
        logic [1:0] family;
        logic       code_needed;
        t_step      step_now;
        t_step      step_next;
        logic [4:0] hold_frames;
        logic [7:0] rows_hit;
        t_seq       seq_kind;
        t_reply     awaited[$];
        int         faults;

        function new();
            family      = FAM_48K;
            code_needed = 1'b0;
            step_now    = S_IDLE;
            step_next   = S_IDLE;
            hold_frames = 5'd0;
            rows_hit    = 8'h00;
            seq_kind    = SEQ_JPP;
            faults      = 0;
        endfunction

        function void note_fault(string msg);
            faults++;
            if (faults <= MAX_REPORTS) begin
                $display("%0t: %s", $time, msg);
            end
        endfunction

        function void set_register(logic idx, logic [31:0] value);
            if (idx == REG_MACHINE_FAMILY) begin
                family = value[1:0];
            end else begin
                code_needed = value[0];
            end
        endfunction

        // Column bit of one key, cleared when its half-row is selected.
        function logic [7:0] key_hit(logic [7:0] port, int row, int col);
            if (port[row]) begin
                return 8'hFF;
            end
            return ~(8'h01 << col);
        endfunction

        // Byte returned by a read in a typing step.
        function logic [7:0] typed_byte(t_step s, logic [7:0] port);
            case (s)
                S_J:                      return key_hit(port, 6, 3);
                S_Q1, S_Q2:               return key_hit(port, 7, 1) & key_hit(port, 5, 0);
                S_ENT, S_ENT_ONLY, S_SEL: return key_hit(port, 6, 0);
                S_L:                      return key_hit(port, 6, 1);
                S_O, S_CO:                return key_hit(port, 5, 1);
                S_A:                      return key_hit(port, 1, 0);
                S_D, S_CD:                return key_hit(port, 1, 2);
                S_EXT:                    return key_hit(port, 0, 0) & key_hit(port, 7, 1);
                S_KW_CODE:                return key_hit(port, 5, 2);
                S_C:                      return key_hit(port, 0, 3);
                S_CE:                     return key_hit(port, 2, 2);
                S_DOWN:                   return key_hit(port, 0, 0) & key_hit(port, 4, 4);
                default:                  return 8'hFF;
            endcase
        endfunction

        function t_step step_after(t_step s);
            case (s)
                S_J:       return S_Q1;
                S_Q1:      return S_Q2;
                S_L:       return S_O;
                S_O:       return S_A;
                S_A:       return S_D;
                S_D:       return S_Q1;
                S_EXT:     return S_KW_CODE;
                S_KW_CODE: return S_ENT;
                S_C:       return S_CO;
                S_CO:      return S_CD;
                S_CD:      return S_CE;
                S_CE:      return S_ENT;
                S_DOWN:    return S_SEL;
                S_SEL:     return S_PAUSE;
                S_PAUSE:   return S_L;
                S_Q2: begin
                    // The closing quotes lead on according to the chosen sequence.
                    case (seq_kind)
                        SEQ_JPP, SEQ_LOADPP:       return S_ENT;
                        SEQ_JPPI:                  return S_EXT;
                        SEQ_DOWN_CODE, SEQ_LOADCODE: return S_C;
                        default:                   return S_IDLE;
                    endcase
                end
                default:   return S_IDLE;
            endcase
        endfunction

        function logic [4:0] frames_held(t_step s);
            case (s)
                S_J:                                      return 5'd8;
                S_Q2:                                     return 5'd5;
                S_ENT_ONLY:                               return 5'd3;
                S_L:                                      return 5'd2;
                S_A, S_D, S_KW_CODE, S_CO, S_CE, S_DOWN:  return 5'd4;
                S_SEL:                                    return 5'd10;
                S_PAUSE:                                  return 5'd28;
                default:                                  return 5'd0;
            endcase
        endfunction

        function t_step entry_step();
            case (seq_kind)
                SEQ_JPP, SEQ_JPPI:         return S_J;
                SEQ_ENTER:                 return S_ENT_ONLY;
                SEQ_DOWN_CODE:             return S_DOWN;
                SEQ_LOADPP, SEQ_LOADCODE:  return S_L;
                default:                   return S_IDLE;
            endcase
        endfunction

        function logic [7:0] read_port(logic [7:0] port);
            if (hold_frames != 5'd0 || step_now == S_IDLE) begin
                return 8'hFF;
            end
            if (step_now == S_WAIT_ROWS) begin
                // Only reads that select exactly one half-row are recorded.
                if ($countones(port) == 7) begin
                    rows_hit |= ~port;
                end
                if (rows_hit == 8'hFF) begin
                    step_next = entry_step();
                end
                return 8'hFF;
            end
            step_next = step_after(step_now);
            return typed_byte(step_now, port);
        endfunction

        function void frame_end();
            rows_hit = 8'h00;
            if (step_next != step_now) begin
                step_now    = step_next;
                hold_frames = frames_held(step_now);
            end
            if (hold_frames != 5'd0) begin
                hold_frames--;
            end
        endfunction

        function void activate();
            case (family)
                FAM_48K:  seq_kind = code_needed ? SEQ_JPPI : SEQ_JPP;
                FAM_128K: seq_kind = code_needed ? SEQ_DOWN_CODE : SEQ_ENTER;
                FAM_SE:   seq_kind = code_needed ? SEQ_LOADCODE : SEQ_LOADPP;
                default:  seq_kind = SEQ_JPP;
            endcase
            step_now  = S_WAIT_ROWS;
            step_next = S_WAIT_ROWS;
        endfunction

        // Called for each accepted input transfer.
        function void note_item(logic [1:0] mode, logic [7:0] port);
            t_reply r;
            r.key_data = 8'hFF;
            case (mode)
                MODE_READ:     r.key_data = read_port(port);
                MODE_FRAME:    frame_end();
                MODE_ACTIVATE: activate();
                default: ;
            endcase
            r.typing_active = (step_now != S_IDLE);
            awaited.push_back(r);
        endfunction

        // Called for each accepted output transfer.
        function void check_reply(logic [7:0] data, logic active);
            t_reply e;
            if (awaited.size() == 0) begin
                note_fault($sformatf("unexpected result: key_data %02h typing_active %0b",
                                     data, active));
                return;
            end
            e = awaited.pop_front();
            if (data !== e.key_data) begin
                note_fault($sformatf("key_data: expected %02h, got %02h", e.key_data, data));
            end
            if (active !== e.typing_active) begin
                note_fault($sformatf("typing_active: expected %0b, got %0b",
                                     e.typing_active, active));
            end
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] port_high
    logic [1:0]  s_axis_tuser;   // [1:0] mode
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // [7:0] key_data
    logic [0:0]  m_axis_tuser;   // [0] typing_active
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    typist_tracker typist;
    bit gaps_on;
    bit stalls_on;

    auto_load_key_typist u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Safety net against a hung handshake.
    initial begin
        #20_000_000;
        $display("auto_load_key_typist_test NOT OK");
        $finish;
    end

    // Receiver: checks each output transfer and stalls in random bursts.
    initial begin
        int stall_left;
        stall_left = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                typist.check_reply(m_axis_tdata, m_axis_tuser[0]);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (stalls_on && $urandom_range(0, 99) < 10) begin
                stall_left = $urandom_range(1, 14) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Offers one item and returns at the edge where its transfer happens.
    task automatic send_item(input logic [1:0] mode, input logic [7:0] port);
        if (gaps_on && $urandom_range(0, 99) < 12) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= port;
        do @(posedge i_clk); while (!s_axis_tready);
        typist.note_item(mode, port);
    endtask

    // Writes a register, reads it back and updates the tracked setting.
    task automatic write_register(input logic idx, input logic [31:0] value);
        logic [31:0] seen;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        typist.set_register(idx, value);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        seen = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (seen !== value) begin
            typist.note_fault($sformatf("register %0d: expected %08h, read %08h",
                                        idx, value, seen));
        end
    endtask

    // Stops sending and waits until every reply has come back.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (typist.outstanding() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // Mostly well-formed typing sessions, with noise and broken sequences mixed in.
    task automatic pick_item(output logic [1:0] mode, output logic [7:0] port);
        int roll;
        int pick;
        int row;
        roll = $urandom_range(0, 999);
        pick = $urandom_range(0, 99);
        port = 8'($urandom);
        mode = MODE_READ;
        if (roll < 8) begin
            mode = MODE_SPARE;
        end else if (typist.step_now == S_IDLE) begin
            if (roll < 800) begin
                mode = MODE_ACTIVATE;
            end else if (roll < 900) begin
                mode = MODE_FRAME;
            end
        end else if (roll < 12) begin
            mode = MODE_ACTIVATE;
        end else if (typist.hold_frames != 5'd0) begin
            if (roll < 880) begin
                mode = MODE_FRAME;
            end
        end else if (typist.step_now == S_WAIT_ROWS) begin
            if (typist.step_next != S_WAIT_ROWS) begin
                if (roll < 700) begin
                    mode = MODE_FRAME;
                end
            end else if (roll < 60) begin
                mode = MODE_FRAME;
            end else if (roll < 900) begin
                // Single half-row reads, usually one not seen yet this frame.
                row = $urandom_range(0, 7);
                if (pick < 75) begin
                    repeat (8) begin
                        if (typist.rows_hit[row]) begin
                            row = (row + 1) % 8;
                        end
                    end
                end
                port = ~(8'h01 << row);
            end
        end else if (typist.step_next != typist.step_now && roll < 500) begin
            mode = MODE_FRAME;
        end else if (pick < 40) begin
            port = 8'h00;
        end else if (pick < 75) begin
            port = ~(8'h01 << $urandom_range(0, 7));
        end
    endtask

    task automatic run_random(input int count);
        int done;
        logic [1:0] mode;
        logic [7:0] port;
        done = 0;
        while (done < count) begin
            pick_item(mode, port);
            done++;
            send_item(mode, port);
        end
    endtask

    // Short directed opening: idle behavior, the row gathering and a restart.
    task automatic run_directed();
        int r;
        send_item(MODE_SPARE, 8'h00);
        send_item(MODE_READ, 8'h00);
        send_item(MODE_FRAME, 8'hFF);
        send_item(MODE_ACTIVATE, 8'h5A);
        send_item(MODE_READ, 8'hFF);
        send_item(MODE_READ, 8'h00);
        send_item(MODE_READ, 8'hFC);
        for (r = 0; r < 8; r++) begin
            send_item(MODE_READ, ~(8'h01 << r));
        end
        send_item(MODE_READ, 8'hFE);
        send_item(MODE_FRAME, 8'h00);
        send_item(MODE_READ, 8'h00);
        send_item(MODE_SPARE, 8'hFF);
        send_item(MODE_ACTIVATE, 8'hA5);
        send_item(MODE_READ, 8'hFE);
        send_item(MODE_FRAME, 8'h00);
    endtask

    initial begin
        logic [1:0] families [PHASES];
        logic       codes [PHASES];
        int ph;
        families = '{2'd0, 2'd3, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd3};
        codes    = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
        typist = new();
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        s_axis_tuser  <= MODE_READ;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= 3'd0;
        pwdata        <= 32'd0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();

        // Each phase runs under its own setting; the last one has no idling.
        for (ph = 0; ph < PHASES; ph++) begin
            gaps_on   = (ph % 3 != 1) && (ph != PHASES - 1);
            stalls_on = (ph % 4 != 2) && (ph != PHASES - 1);
            wait_drained();
            write_register(REG_MACHINE_FAMILY, {30'd0, families[ph]});
            write_register(REG_LOAD_CODE, {31'd0, codes[ph]});
            run_random(191);
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (typist.faults == 0 && typist.outstanding() == 0) begin
            $display("auto_load_key_typist_test OK");
        end else begin
            $display("auto_load_key_typist_test NOT OK");
        end
        $finish;
    end

endmodule
